// ===== design/plist_pkg.sv =====
`timescale 1ns / 1ps

package plist_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int ST_W  = 2;
  localparam int LEN_W = 7;

  localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_LAST  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DISPLAY   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd7;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic             load;       // latch item, status and sweep setup
    logic             up;         // entries move toward the back
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] ra;
    logic [LEN_W-1:0] n;
    logic [ST_W-1:0]  st;
    logic             shift;
    logic             rd;
    logic             put;
    logic             drop;
    logic             emit_elem;
    logic             emit_stat;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic             shift_done;
    logic             more;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== design/plist_if.sv =====
`timescale 1ns / 1ps

interface plist_req_if import plist_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, cmd, item_value, position, input ready);
  modport sink   (input valid, cmd, item_value, position, output ready);
endinterface

interface plist_rsp_if import plist_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] out_value;
  logic [LEN_W-1:0]        length;
  logic                    last;

  modport source (output valid, status, out_value, length, last, input ready);
  modport sink   (input valid, status, out_value, length, last, output ready);
endinterface

// ===== design/plist_ctrl.sv =====
`timescale 1ns / 1ps

module plist_ctrl import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] req_cmd,
  input  logic [POS_W-1:0] req_pos,
  output logic             req_ready,
  input  dp_stat_t         stat,
  output dp_ctl_t          ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT    = 3'd1;
  localparam logic [2:0] S_DISP_RD  = 3'd2;
  localparam logic [2:0] S_DISP_OUT = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;

  logic [2:0] state, state_next;
  logic       is_ins, is_ins_next;

  logic [POS_W:0]   c_ext, p_ext;
  logic [LEN_W-1:0] c, pidx, ins_idx, del_idx;
  logic             full, empty, bad_ins, bad_del;

  assign c       = stat.count;
  assign c_ext   = (POS_W+1)'(c);
  assign p_ext   = (POS_W+1)'(req_pos);
  assign pidx    = LEN_W'(p_ext - 1'b1);
  assign full    = (c >= LEN_W'(CAPACITY));
  assign empty   = (c == '0);
  assign bad_ins = (req_pos == '0) || (p_ext > c_ext + 1'b1);
  assign bad_del = (req_pos == '0) || (p_ext > c_ext);

  always_comb begin
    case (req_cmd)
      CMD_INS_FIRST: ins_idx = '0;
      CMD_INS_LAST:  ins_idx = c;
      default:       ins_idx = pidx;
    endcase
    case (req_cmd)
      CMD_DEL_FIRST: del_idx = '0;
      CMD_DEL_LAST:  del_idx = c - 1'b1;
      default:       del_idx = pidx;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    is_ins_next = is_ins;
    ctl         = '0;
    ctl.st      = ST_OK;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_RESP;
          case (req_cmd) inside
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
              if (req_cmd == CMD_INS_POS && bad_ins) begin
                ctl.st = ST_BADPOS;
              end else if (full) begin
                ctl.st = ST_FULL;
              end else begin
                ctl.up      = 1'b1;
                ctl.idx     = ins_idx;
                ctl.ra      = c - 1'b1;
                ctl.n       = c - ins_idx;
                is_ins_next = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
              if (empty) begin
                ctl.st = ST_EMPTY;
              end else if (req_cmd == CMD_DEL_POS && bad_del) begin
                ctl.st = ST_BADPOS;
              end else begin
                ctl.up      = 1'b0;
                ctl.idx     = del_idx;
                ctl.ra      = del_idx + 1'b1;
                ctl.n       = c - 1'b1 - del_idx;
                is_ins_next = 1'b0;
                state_next  = S_SHIFT;
              end
            end
            CMD_DISPLAY: begin
              if (!empty) begin
                ctl.ra     = '0;
                ctl.n      = c;
                state_next = S_DISP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        ctl.shift = 1'b1;
        if (stat.shift_done) begin
          ctl.put    = is_ins;
          ctl.drop   = !is_ins;
          state_next = S_RESP;
        end
      end
      S_DISP_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (stat.out_free) begin
          ctl.emit_elem = 1'b1;
          // fetch the next element while this one goes out
          if (stat.more) begin
            ctl.rd = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctl.emit_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      is_ins <= 1'b0;
    end else begin
      state  <= state_next;
      is_ins <= is_ins_next;
    end
  end

endmodule

// ===== design/plist_dp.sv =====
`timescale 1ns / 1ps

module plist_dp import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [VAL_W-1:0] item_value,
  input  dp_ctl_t                 ctl,
  output dp_stat_t                stat,
  plist_rsp_if.source             result
);

  localparam int AW = $clog2(CAPACITY);

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [LEN_W-1:0] count, n;
  logic [AW-1:0]    ra, wa, idx;
  logic             up, rv, out_valid;
  logic [ST_W-1:0]  st;
  logic [VAL_W-1:0] value, rdata;
  logic             rd_en;

  assign rd_en = ctl.rd || (ctl.shift && n != '0);

  assign stat.count      = count;
  assign stat.shift_done = (n == '0) && !rv;
  assign stat.more       = (n != '0);
  assign stat.out_free   = !out_valid || result.ready;

  assign result.valid = out_valid;

  // store: one read and one write port; a moved entry is written back
  // the cycle after its read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[ra];
    end
    if (rv) begin
      mem[wa] <= rdata;
    end else if (ctl.put) begin
      mem[idx] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= item_value;
      st    <= ctl.st;
      up    <= ctl.up;
      idx   <= ctl.idx[AW-1:0];
      ra    <= ctl.ra[AW-1:0];
      n     <= ctl.n;
    end else if (rd_en) begin
      ra <= up ? ra - 1'b1 : ra + 1'b1;
      wa <= up ? ra + 1'b1 : ra - 1'b1;
      n  <= n - 1'b1;
    end
    if (ctl.emit_elem) begin
      result.status    <= ST_OK;
      result.out_value <= rdata;
      result.length    <= count;
      result.last      <= (n == '0);
    end else if (ctl.emit_stat) begin
      result.status    <= st;
      result.out_value <= '0;
      result.length    <= count;
      result.last      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rv <= ctl.shift && (n != '0);
      if (ctl.put) begin
        count <= count + 1'b1;
      end else if (ctl.drop) begin
        count <= count - 1'b1;
      end
      if (ctl.emit_elem || ctl.emit_stat) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    ctl.put |-> (count < LEN_W'(CAPACITY)) && !rv)
    else $error("insert into full store or during write-back");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.drop |-> count != '0)
    else $error("delete from empty list");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit_elem || ctl.emit_stat) |-> (!out_valid || result.ready))
    else $error("result overwritten before transfer");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(ctl.put) && !$past(ctl.drop) && !$past(rst)) |-> $stable(count))
    else $error("length changed without insert or delete");

endmodule

// ===== design/positional_list_engine_top.sv =====
`timescale 1ns / 1ps

// Channel   Modport  Payload                             Transfer
// request   sink     cmd, item_value, position           valid && ready
// result    source   status, out_value, length, last     valid && ready
//
// One command at a time. Insert/delete moves its m entries one entry per cycle
// through the single read and write port of the store, then gives its result.
// Display: one element per cycle while the result channel is not stalled.
// rst is synchronous and clears the length; store contents are not cleared.
// A stalled result holds; the next request is taken while it waits.

module positional_list_engine_top import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  plist_req_if.sink request,
  plist_rsp_if.source result
);

  dp_ctl_t  ctl;
  dp_stat_t stat;
  logic     ready;

  assign request.ready = ready;

  plist_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_cmd   (request.cmd),
    .req_pos   (request.position),
    .req_ready (ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  plist_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_value (request.item_value),
    .ctl        (ctl),
    .stat       (stat),
    .result     (result)
  );

endmodule

// ===== tb/positional_list_engine_top_tb.sv =====
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
  import plist_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int N_RANDOM    = 280;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLDOFF_LEN = 400;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    bit                      fit_pos;  // position picked against the live list size
    bit                      hold;     // wait for all results before offering
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  plist_req_if request_if ();
  plist_rsp_if result_if ();

  positional_list_engine_top #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .request(request_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  list_cmd_t               pend_q[$];
  list_result_t            due_q[$];
  logic signed [VAL_W-1:0] list_q[$];

  int unsigned n_sent     = 0;
  int unsigned n_expected = 0;
  int unsigned n_checked  = 0;
  int unsigned n_err      = 0;
  int unsigned peak_len   = 0;
  int unsigned st_seen[4] = '{0, 0, 0, 0};
  int unsigned cycles     = 0;

  logic [CMD_W-1:0] ins_cmds[3] = '{CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS};
  logic [CMD_W-1:0] del_cmds[3] = '{CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS};

  // ---------------------------------------------------------------------------
  // List predictor: applies one command and queues the results it causes
  // ---------------------------------------------------------------------------
  task automatic run_list_cmd(input logic [CMD_W-1:0] cmd,
                              input logic signed [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned  n;
    bit           shown;
    n        = list_q.size();
    shown    = 1'b0;
    r.status = ST_OK;
    r.value  = '0;
    r.last   = 1'b1;
    case (cmd)
      CMD_INS_FIRST, CMD_INS_LAST: begin
        if (n >= CAP) r.status = ST_FULL;
        else if (cmd == CMD_INS_FIRST) list_q.push_front(val);
        else list_q.push_back(val);
      end
      CMD_INS_POS: begin
        // position is checked ahead of the full condition
        if (pos == 0 || pos > n + 1) r.status = ST_BADPOS;
        else if (n >= CAP) r.status = ST_FULL;
        else list_q.insert(pos - 1, val);
      end
      CMD_DEL_FIRST: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(list_q.pop_front());
      end
      CMD_DEL_LAST: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(list_q.pop_back());
      end
      CMD_DEL_POS: begin
        // empty wins over a bad position
        if (n == 0) r.status = ST_EMPTY;
        else if (pos == 0 || pos > n) r.status = ST_BADPOS;
        else list_q.delete(pos - 1);
      end
      CMD_DISPLAY: begin
        for (int i = 0; i < n; i++) begin
          r.value  = list_q[i];
          r.length = LEN_W'(n);
          r.last   = (i == n - 1);
          due_q.push_back(r);
          n_expected++;
          shown = 1'b1;
        end
      end
      CMD_COUNT: ;
      default: ;
    endcase
    if (!shown) begin
      r.length = LEN_W'(list_q.size());
      due_q.push_back(r);
      n_expected++;
    end
    st_seen[r.status]++;
    if (list_q.size() > peak_len) peak_len = list_q.size();
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                         input logic [POS_W-1:0] pos, input bit fit, input bit hold);
    list_cmd_t c;
    c.cmd     = cmd;
    c.value   = val;
    c.pos     = pos;
    c.fit_pos = fit;
    c.hold    = hold;
    pend_q.push_back(c);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    list_cmd_t nxt;
    bit        fire;
    bit        go;
    if (rst) begin
      request_if.valid      <= 1'b0;
      request_if.cmd        <= CMD_COUNT;
      request_if.item_value <= '0;
      request_if.position   <= '0;
    end else begin
      fire = request_if.valid && request_if.ready;
      go   = 1'b0;
      if (fire) begin
        run_list_cmd(request_if.cmd, request_if.item_value, request_if.position);
        n_sent++;
      end
      if (fire || !request_if.valid) begin
        if (pend_q.size() != 0) begin
          if (pend_q[0].hold && n_checked != n_expected) go = 1'b0;
          else if (gap_left != 0) gap_left--;
          else go = 1'b1;
        end
        if (go) begin
          nxt = pend_q.pop_front();
          if (nxt.fit_pos) nxt.pos = POS_W'($urandom_range(1, list_q.size() + 1));
          request_if.cmd        <= nxt.cmd;
          request_if.item_value <= nxt.value;
          request_if.position   <= nxt.pos;
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 10);
            gap_left   = $urandom_range(0, 7);
          end
        end
        request_if.valid <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern, long holdoff, checker
  // ---------------------------------------------------------------------------
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick      = 0;
  int unsigned hold_cnt     = 0;
  bit          hold_done    = 1'b0;
  logic        rx_hold      = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 1'b0;
    end else begin
      if (!hold_done && n_checked >= 100) begin
        hold_done = 1'b1;
        hold_cnt  = HOLDOFF_LEN;
      end else if (hold_cnt != 0) begin
        hold_cnt--;
      end
      rx_hold <= (hold_cnt != 0);
    end
  end

  always @(posedge clk) begin
    bit open;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(30, 200);
      end else begin
        rx_mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        0:       open = 1'b1;
        1:       open = $urandom_range(0, 1);
        2:       open = (rx_tick % 4 == 0);
        default: open = ($urandom_range(0, 7) != 0);
      endcase
      result_if.ready <= open && !rx_hold;
    end
  end

  always @(posedge clk) begin
    list_result_t e;
    if (!rst && result_if.valid && result_if.ready) begin
      if (due_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result: status %0d value %0d length %0d last %0b",
                   result_if.status, result_if.out_value, result_if.length, result_if.last);
      end else begin
        e = due_q.pop_front();
        if (result_if.status !== e.status || result_if.out_value !== e.value ||
            result_if.length !== e.length || result_if.last !== e.last) begin
          n_err++;
          if (n_err <= 10) begin
            $write("mismatch at result %0d (exp/act): status %0d/%0d value %0d/%0d",
                   n_checked, e.status, result_if.status, e.value, result_if.out_value);
            $display(" length %0d/%0d last %0b/%0b",
                     e.length, result_if.length, e.last, result_if.last);
          end
        end
      end
      n_checked <= n_checked + 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_rand;
    int unsigned phase;
    int unsigned kind;
    int unsigned plen;
    int unsigned roll;
    int unsigned pick;
    logic [POS_W-1:0] p;
    bit fit;

    rst                   = 1'b1;
    request_if.valid      = 1'b0;
    request_if.cmd        = CMD_COUNT;
    request_if.item_value = '0;
    request_if.position   = '0;
    result_if.ready       = 1'b0;

    // empty list corner cases, then edges of the position range
    add_cmd(CMD_DISPLAY,   '0, 8'd0, 0, 0);
    add_cmd(CMD_COUNT,     '0, 8'd0, 0, 0);
    add_cmd(CMD_DEL_FIRST, '0, 8'd0, 0, 0);
    add_cmd(CMD_DEL_LAST,  '0, 8'd0, 0, 0);
    add_cmd(CMD_DEL_POS,   '0, 8'd0, 0, 0);
    add_cmd(CMD_INS_POS,   32'sd5, 8'd0, 0, 0);
    add_cmd(CMD_INS_POS,   32'sd6, 8'd2, 0, 0);
    add_cmd(CMD_INS_FIRST, 32'sh7fff_ffff, 8'd0, 0, 0);
    add_cmd(CMD_INS_LAST,  32'sh8000_0000, 8'd0, 0, 0);
    add_cmd(CMD_INS_POS,   -32'sd1, 8'd1, 0, 0);
    add_cmd(CMD_INS_POS,   '0, 8'd4, 0, 0);
    add_cmd(CMD_INS_POS,   32'sd9, 8'd255, 0, 0);
    add_cmd(CMD_DEL_POS,   '0, 8'd0, 0, 0);
    add_cmd(CMD_DEL_POS,   '0, 8'd5, 0, 0);
    add_cmd(CMD_DEL_POS,   '0, 8'd255, 0, 0);
    add_cmd(CMD_DISPLAY,   '0, 8'd0, 0, 0);
    add_cmd(CMD_DEL_POS,   '0, 8'd4, 0, 0);
    add_cmd(CMD_DEL_POS,   '0, 8'd2, 0, 0);
    add_cmd(CMD_DEL_FIRST, '0, 8'd0, 0, 0);
    add_cmd(CMD_DEL_LAST,  '0, 8'd0, 0, 0);
    add_cmd(CMD_COUNT,     '0, 8'd0, 0, 0);
    add_cmd(CMD_DISPLAY,   '0, 8'd0, 0, 0);

    // random phases: fill to full first, drain to empty later, mixed traffic between and after
    n_rand = 0;
    phase  = 0;
    while (n_rand < N_RANDOM) begin
      if (phase == 0) kind = 0;
      else if (phase == 3) kind = 4;
      else kind = $urandom_range(1, 3);
      plen = (kind == 0 || kind == 4) ? 40 : $urandom_range(15, 40);
      for (int i = 0; i < plen; i++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0:       pick = 0;
          1:       pick = (roll < 70) ? 0 : (roll < 85) ? 1 : (roll < 92) ? 2 : 3;
          2:       pick = (roll < 15) ? 0 : (roll < 85) ? 1 : (roll < 92) ? 2 : 3;
          3:       pick = (roll < 40) ? 0 : (roll < 80) ? 1 : (roll < 90) ? 2 : 3;
          default: pick = 1;
        endcase
        roll = $urandom_range(0, 19);
        fit  = (roll >= 3);
        p    = (roll == 0) ? 8'd0 : POS_W'($urandom_range(0, 255));
        case (pick)
          0: add_cmd(ins_cmds[$urandom_range(0, 2)], rand_value(), p, fit,
                     (i == 0) && (phase % 4 == 1));
          1: add_cmd(del_cmds[$urandom_range(0, 2)], rand_value(), p, fit,
                     (i == 0) && (phase % 4 == 1));
          2: add_cmd(CMD_DISPLAY, rand_value(), p, 0, (i == 0) && (phase % 4 == 1));
          default: add_cmd(CMD_COUNT, rand_value(), p, 0, (i == 0) && (phase % 4 == 1));
        endcase
        n_rand++;
      end
      if (kind == 0) begin
        // list is full by now: refused inserts and a full-length display
        add_cmd(CMD_INS_POS, rand_value(), 8'd255, 0, 0);
        add_cmd(CMD_INS_POS, rand_value(), 8'd0, 1, 0);
        add_cmd(CMD_INS_FIRST, rand_value(), 8'd0, 0, 0);
        add_cmd(CMD_DISPLAY, '0, 8'd0, 0, 0);
        n_rand += 4;
      end
      phase++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || request_if.valid) @(posedge clk);
    while (n_checked != n_expected) @(posedge clk);
    repeat (60) @(posedge clk);

    if (due_q.size() != 0) begin
      n_err++;
      $display("%0d expected results never arrived", due_q.size());
    end
    $display("ran %0d commands, checked %0d results, peak list length %0d of %0d",
             n_sent, n_checked, peak_len, CAP);
    $display("status counts: ok %0d, bad position %0d, full %0d, empty %0d; errors %0d",
             st_seen[ST_OK], st_seen[ST_BADPOS], st_seen[ST_FULL], st_seen[ST_EMPTY], n_err);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
